>>> sv/prs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pump relay supervisor.
// No dependencies; every other file of the block imports this package.
package prs_pkg;

	localparam int unsigned TS_W    = 32;
	localparam int unsigned SETTLE_W = 16;
	localparam int unsigned CHAT_W  = 4;
	localparam int unsigned START_W = 16;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [IDX_W-1:0] REG_SETTLE_MS     = 3'd0;
	localparam logic [IDX_W-1:0] REG_BREAK_MS      = 3'd1;
	localparam logic [IDX_W-1:0] REG_CHATTER_LIMIT = 3'd2;
	localparam logic [IDX_W-1:0] REG_WINDOW_MS     = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOCK_MS       = 3'd4;

	localparam logic [SETTLE_W-1:0] SETTLE_MS_RST     = 16'd500;
	localparam logic [TS_W-1:0]     BREAK_MS_RST      = 32'd30000;
	localparam logic [CHAT_W-1:0]   CHATTER_LIMIT_RST = 4'd5;
	localparam logic [TS_W-1:0]     WINDOW_MS_RST     = 32'd10000;
	localparam logic [TS_W-1:0]     LOCK_MS_RST       = 32'd300000;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic [SETTLE_W-1:0] settle_ms;
		logic [TS_W-1:0]     break_ms;
		logic [CHAT_W-1:0]   chatter_limit;
		logic [TS_W-1:0]     window_ms;
		logic [TS_W-1:0]     lock_ms;
	} cfg_t;

	typedef struct packed {
		logic            op;
		logic [TS_W-1:0] now_ms;
		logic            want_on;
		logic            safe_ok;
		logic            feedback_on;
	} item_t;

	typedef struct packed {
		logic               pump_on;
		logic               fault_lamp;
		logic               wire_fault;
		logic               locked_out;
		logic               chatter_trip;
		logic [TS_W-1:0]    run_total_ms;
		logic [START_W-1:0] start_count;
	} result_t;

endpackage

>>> sv/prs_item_if.sv
`timescale 1ns / 1ps
// Input channel of the pump relay supervisor: valid/ready plus one tick or clear op.
// Depends on prs_pkg for field widths.
interface prs_item_if;
	import prs_pkg::*;

	logic            valid;
	logic            ready;
	logic            op;
	logic [TS_W-1:0] now_ms;
	logic            want_on;
	logic            safe_ok;
	logic            feedback_on;

	modport source (output valid, op, now_ms, want_on, safe_ok, feedback_on, input ready);
	modport sink   (input valid, op, now_ms, want_on, safe_ok, feedback_on, output ready);
endinterface

>>> sv/prs_result_if.sv
`timescale 1ns / 1ps
// Output channel of the pump relay supervisor: valid/ready plus one status result.
// Depends on prs_pkg for field widths.
interface prs_result_if;
	import prs_pkg::*;

	logic               valid;
	logic               ready;
	logic               pump_on;
	logic               fault_lamp;
	logic               wire_fault;
	logic               locked_out;
	logic               chatter_trip;
	logic [TS_W-1:0]    run_total_ms;
	logic [START_W-1:0] start_count;

	modport source (output valid, pump_on, fault_lamp, wire_fault, locked_out, chatter_trip,
		run_total_ms, start_count, input ready);
	modport sink   (input valid, pump_on, fault_lamp, wire_fault, locked_out, chatter_trip,
		run_total_ms, start_count, output ready);
endinterface

>>> sv/prs_core.sv
`timescale 1ns / 1ps
// Supervisor state and single-pass next-state logic for one transaction.
// Depends on prs_pkg; state advances when en is high.
module prs_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  prs_pkg::item_t  item,
	input  prs_pkg::cfg_t   cfg,
	output prs_pkg::result_t res
);
	import prs_pkg::*;

	logic               pump_cmd_q, lamp_q, broken_q, prev_valid_q, mis_active_q;
	logic [TS_W-1:0]    prev_tick_q, mis_start_q, last_change_q, window_start_q;
	logic [TS_W-1:0]    lock_until_q, run_total_q;
	logic [CHAT_W-1:0]  change_count_q;
	logic [START_W-1:0] starts_q;

	logic               pump_cmd_d, lamp_d, broken_d, prev_valid_d, mis_active_d;
	logic [TS_W-1:0]    prev_tick_d, mis_start_d, last_change_d, window_start_d;
	logic [TS_W-1:0]    lock_until_d, run_total_d;
	logic [CHAT_W-1:0]  change_count_d;
	logic [START_W-1:0] starts_d;
	logic               trip;

	logic [TS_W:0]      run_sum;
	logic [TS_W-1:0]    mis_base;
	logic [CHAT_W-1:0]  cnt_base, cnt_inc;
	logic               settled, win_expired, locked_pre;

	assign run_sum     = {1'b0, run_total_q} + {1'b0, item.now_ms - prev_tick_q};
	assign settled     = (item.now_ms - last_change_q) > {{(TS_W-SETTLE_W){1'b0}}, cfg.settle_ms};
	assign mis_base    = mis_active_q ? mis_start_q : item.now_ms;
	assign win_expired = (item.now_ms - window_start_q) > cfg.window_ms;
	assign cnt_base    = win_expired ? '0 : change_count_q;
	assign cnt_inc     = cnt_base + CHAT_W'(1);
	assign locked_pre  = item.now_ms < lock_until_q;

	always_comb begin
		pump_cmd_d     = pump_cmd_q;
		lamp_d         = lamp_q;
		broken_d       = broken_q;
		prev_valid_d   = prev_valid_q;
		mis_active_d   = mis_active_q;
		prev_tick_d    = prev_tick_q;
		mis_start_d    = mis_start_q;
		last_change_d  = last_change_q;
		window_start_d = window_start_q;
		lock_until_d   = lock_until_q;
		run_total_d    = run_total_q;
		change_count_d = change_count_q;
		starts_d       = starts_q;
		trip           = 1'b0;

		if (item.op == OP_CLEAR) begin
			starts_d = '0;
		end else begin
			if (prev_valid_q && pump_cmd_q) begin
				run_total_d = run_sum[TS_W] ? '1 : run_sum[TS_W-1:0];
			end
			prev_tick_d  = item.now_ms;
			prev_valid_d = 1'b1;

			if (!broken_q && settled) begin
				if (item.feedback_on != pump_cmd_q) begin
					mis_start_d  = mis_base;
					mis_active_d = 1'b1;
					if ((item.now_ms - mis_base) > cfg.break_ms) begin
						broken_d = 1'b1;
					end
				end else begin
					mis_active_d = 1'b0;
				end
			end

			if (locked_pre) begin
				if (pump_cmd_q) begin
					pump_cmd_d    = 1'b0;
					last_change_d = item.now_ms;
				end
			end else if (item.safe_ok) begin
				lamp_d = 1'b0;
				if (item.want_on != pump_cmd_q) begin
					if (win_expired) begin
						window_start_d = item.now_ms;
					end
					if (cnt_inc >= cfg.chatter_limit) begin
						lock_until_d   = item.now_ms + cfg.lock_ms;
						change_count_d = '0;
						pump_cmd_d     = 1'b0;
						last_change_d  = item.now_ms;
						trip           = 1'b1;
						lamp_d         = lamp_q;
					end else begin
						change_count_d = cnt_inc;
						pump_cmd_d     = item.want_on;
						last_change_d  = item.now_ms;
						if (item.want_on && (starts_q != '1)) begin
							starts_d = starts_q + START_W'(1);
						end
					end
				end
			end else begin
				if (pump_cmd_q) begin
					pump_cmd_d    = 1'b0;
					last_change_d = item.now_ms;
				end
				lamp_d = 1'b1;
			end
		end
	end

	always_comb begin
		res.pump_on      = pump_cmd_d;
		res.fault_lamp   = lamp_d;
		res.wire_fault   = broken_d;
		res.locked_out   = item.now_ms < lock_until_d;
		res.chatter_trip = trip;
		res.run_total_ms = run_total_d;
		res.start_count  = starts_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_cmd_q     <= 1'b0;
			lamp_q         <= 1'b0;
			broken_q       <= 1'b0;
			prev_valid_q   <= 1'b0;
			mis_active_q   <= 1'b0;
			prev_tick_q    <= '0;
			mis_start_q    <= '0;
			last_change_q  <= '0;
			window_start_q <= '0;
			lock_until_q   <= '0;
			run_total_q    <= '0;
			change_count_q <= '0;
			starts_q       <= '0;
		end else if (en) begin
			pump_cmd_q     <= pump_cmd_d;
			lamp_q         <= lamp_d;
			broken_q       <= broken_d;
			prev_valid_q   <= prev_valid_d;
			mis_active_q   <= mis_active_d;
			prev_tick_q    <= prev_tick_d;
			mis_start_q    <= mis_start_d;
			last_change_q  <= last_change_d;
			window_start_q <= window_start_d;
			lock_until_q   <= lock_until_d;
			run_total_q    <= run_total_d;
			change_count_q <= change_count_d;
			starts_q       <= starts_d;
		end
	end
endmodule

>>> sv/pump_relay_supervisor_unit.sv
`timescale 1ns / 1ps
// Pump relay supervisor top level: config registers, input stage, result register.
// Each accepted transaction is held in the input stage, then in the result register.
// Throughput: one transaction per cycle when not stalled; the state update is one pass of prs_core logic.
// Backpressure stalls the input stage only while the result register is full and not taken.
// Reset clears all supervisor state, both stage valid flags, and loads config defaults.
// Depends on prs_pkg, prs_item_if, prs_result_if and prs_core.
module pump_relay_supervisor_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [prs_pkg::IDX_W-1:0] wr_index,
	input  logic [prs_pkg::DATA_W-1:0] wr_data,
	prs_item_if.sink                  item,
	prs_result_if.source              result
);
	import prs_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    res_valid_q;
	result_t res_next;
	item_t   item_in;
	logic    adv;

	assign adv        = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv;

	always_comb begin
		item_in.op          = item.op;
		item_in.now_ms      = item.now_ms;
		item_in.want_on     = item.want_on;
		item_in.safe_ok     = item.safe_ok;
		item_in.feedback_on = item.feedback_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ms     <= SETTLE_MS_RST;
			cfg_q.break_ms      <= BREAK_MS_RST;
			cfg_q.chatter_limit <= CHATTER_LIMIT_RST;
			cfg_q.window_ms     <= WINDOW_MS_RST;
			cfg_q.lock_ms       <= LOCK_MS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_SETTLE_MS:     cfg_q.settle_ms     <= wr_data[SETTLE_W-1:0];
				REG_BREAK_MS:      cfg_q.break_ms      <= wr_data[TS_W-1:0];
				REG_CHATTER_LIMIT: cfg_q.chatter_limit <= wr_data[CHAT_W-1:0];
				REG_WINDOW_MS:     cfg_q.window_ms     <= wr_data[TS_W-1:0];
				REG_LOCK_MS:       cfg_q.lock_ms       <= wr_data[TS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item_in;
		end
	end

	prs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			res_q <= res_next;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.pump_on      = res_q.pump_on;
	assign result.fault_lamp   = res_q.fault_lamp;
	assign result.wire_fault   = res_q.wire_fault;
	assign result.locked_out   = res_q.locked_out;
	assign result.chatter_trip = res_q.chatter_trip;
	assign result.run_total_ms = res_q.run_total_ms;
	assign result.start_count  = res_q.start_count;
endmodule

>>> sv/prs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the pump relay supervisor, bound to the top level.
// Depends on prs_pkg for field widths.
module prs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       pump_on,
	input logic                       chatter_trip,
	input logic [prs_pkg::TS_W-1:0]   run_total_ms,
	input logic [prs_pkg::START_W-1:0] start_count
);
	import prs_pkg::*;

	// hold a stalled result: valid, run_total_ms and start_count stay stable
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(run_total_ms) && $stable(start_count))
		else $error("stalled result changed");

	// drop the pump on the trip transaction
	a_trip_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && chatter_trip |-> !pump_on)
		else $error("pump on during chatter trip");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("input stalled with empty result register");
endmodule

bind pump_relay_supervisor_unit prs_checker u_prs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.pump_on      (result.pump_on),
	.chatter_trip (result.chatter_trip),
	.run_total_ms (result.run_total_ms),
	.start_count  (result.start_count)
);

>>> bench/pump_relay_supervisor_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pump_relay_supervisor_unit: a status tracker predicts every result
// from the accepted ticks and clears, and checks the result channel in order.
// Depends on prs_pkg, prs_item_if, prs_result_if and the supervisor RTL.
module pump_relay_supervisor_unit_tb;
	import prs_pkg::*;

	class prs_status_tracker;
		logic [SETTLE_W-1:0] settle;
		logic [TS_W-1:0]     brk_lim;
		logic [CHAT_W-1:0]   chat_lim;
		logic [TS_W-1:0]     win_len;
		logic [TS_W-1:0]     lock_len;

		logic                relay_cmd;
		logic                lamp_lit;
		logic                wire_broken;
		logic                last_tick_ok;
		logic                mism_open;
		logic [TS_W-1:0]     last_tick;
		logic [TS_W-1:0]     mism_since;
		logic [TS_W-1:0]     cmd_changed_at;
		logic [TS_W-1:0]     win_begin;
		logic [TS_W-1:0]     lockout_end;
		logic [TS_W-1:0]     run_ms;
		logic [CHAT_W-1:0]   toggles;
		logic [START_W-1:0]  start_cnt;

		result_t             status_due[$];
		int                  errors;

		function new();
			settle         = SETTLE_MS_RST;
			brk_lim        = BREAK_MS_RST;
			chat_lim       = CHATTER_LIMIT_RST;
			win_len        = WINDOW_MS_RST;
			lock_len       = LOCK_MS_RST;
			relay_cmd      = 1'b0;
			lamp_lit       = 1'b0;
			wire_broken    = 1'b0;
			last_tick_ok   = 1'b0;
			mism_open      = 1'b0;
			last_tick      = '0;
			mism_since     = '0;
			cmd_changed_at = '0;
			win_begin      = '0;
			lockout_end    = '0;
			run_ms         = '0;
			toggles        = '0;
			start_cnt      = '0;
			errors         = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_SETTLE_MS:     settle   = val[SETTLE_W-1:0];
				REG_BREAK_MS:      brk_lim  = val[TS_W-1:0];
				REG_CHATTER_LIMIT: chat_lim = val[CHAT_W-1:0];
				REG_WINDOW_MS:     win_len  = val[TS_W-1:0];
				REG_LOCK_MS:       lock_len = val[TS_W-1:0];
				default: ;
			endcase
		endfunction

		function void drop_relay(logic [TS_W-1:0] t);
			relay_cmd      = 1'b0;
			cmd_changed_at = t;
		endfunction

		function void note_tick(item_t it);
			logic [TS_W:0]   sum;
			logic [TS_W-1:0] t;
			logic            trip;
			logic            lamp_clear;
			result_t         r;
			t    = it.now_ms;
			trip = 1'b0;
			if (it.op == OP_CLEAR) begin
				start_cnt = '0;
			end else begin
				if (last_tick_ok && relay_cmd) begin
					sum    = {1'b0, run_ms} + {1'b0, TS_W'(t - last_tick)};
					run_ms = sum[TS_W] ? '1 : sum[TS_W-1:0];
				end
				last_tick    = t;
				last_tick_ok = 1'b1;

				if (!wire_broken && (TS_W'(t - cmd_changed_at) > TS_W'(settle))) begin
					if (it.feedback_on != relay_cmd) begin
						if (!mism_open) begin
							mism_since = t;
							mism_open  = 1'b1;
						end
						if (TS_W'(t - mism_since) > brk_lim)
							wire_broken = 1'b1;
					end else begin
						mism_open = 1'b0;
					end
				end

				if (t < lockout_end) begin
					if (relay_cmd)
						drop_relay(t);
				end else if (it.safe_ok) begin
					lamp_clear = 1'b1;
					if (it.want_on != relay_cmd) begin
						if (TS_W'(t - win_begin) > win_len) begin
							win_begin = t;
							toggles   = '0;
						end
						toggles = toggles + 1'b1;
						if (toggles >= chat_lim) begin
							lockout_end = t + lock_len;
							toggles     = '0;
							drop_relay(t);
							trip        = 1'b1;
							lamp_clear  = 1'b0;
						end else begin
							relay_cmd      = it.want_on;
							cmd_changed_at = t;
							if (relay_cmd && start_cnt != '1)
								start_cnt = start_cnt + 1'b1;
						end
					end
					if (lamp_clear)
						lamp_lit = 1'b0;
				end else begin
					if (relay_cmd)
						drop_relay(t);
					lamp_lit = 1'b1;
				end
			end
			r.pump_on      = relay_cmd;
			r.fault_lamp   = lamp_lit;
			r.wire_fault   = wire_broken;
			r.locked_out   = (t < lockout_end);
			r.chatter_trip = trip;
			r.run_total_ms = run_ms;
			r.start_count  = start_cnt;
			status_due.push_back(r);
		endfunction

		function bit field_diff(string name, logic [31:0] exp_v, logic [31:0] got_v);
			if (exp_v !== got_v) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void check_status(result_t got);
			result_t exp_r;
			bit      bad;
			if (status_due.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp_r = status_due.pop_front();
			bad = 1'b0;
			bad |= field_diff("pump_on", exp_r.pump_on, got.pump_on);
			bad |= field_diff("fault_lamp", exp_r.fault_lamp, got.fault_lamp);
			bad |= field_diff("wire_fault", exp_r.wire_fault, got.wire_fault);
			bad |= field_diff("locked_out", exp_r.locked_out, got.locked_out);
			bad |= field_diff("chatter_trip", exp_r.chatter_trip, got.chatter_trip);
			bad |= field_diff("run_total_ms", exp_r.run_total_ms, got.run_total_ms);
			bad |= field_diff("start_count", exp_r.start_count, got.start_count);
			if (bad)
				errors++;
		endfunction

		function int pending();
			return status_due.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [IDX_W-1:0]   wr_index = '0;
	logic [DATA_W-1:0]  wr_data = '0;

	prs_item_if   item_ch ();
	prs_result_if result_ch ();

	prs_status_tracker tracker = new();
	logic [TS_W-1:0]   cur_now = '0;
	int                sent = 0;

	pump_relay_supervisor_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic item_t tick_item(logic op, logic [TS_W-1:0] t, logic w, logic s, logic f);
		item_t it;
		it.op          = op;
		it.now_ms      = t;
		it.want_on     = w;
		it.safe_ok     = s;
		it.feedback_on = f;
		cur_now        = t;
		return it;
	endfunction

	function automatic item_t gen_tick(bit allow_huge);
		item_t       it;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 8)
			cur_now = cur_now;
		else if (sel < 55)
			cur_now = cur_now + $urandom_range(500, 1);
		else if (sel < 88)
			cur_now = cur_now + $urandom_range(6000, 500);
		else if (sel < 94)
			cur_now = cur_now + $urandom_range(60000, 6000);
		else if (allow_huge)
			cur_now = $urandom();
		else
			cur_now = cur_now + $urandom_range(200);
		it.op          = ($urandom_range(99) < 5) ? OP_CLEAR : OP_TICK;
		it.now_ms      = cur_now;
		it.want_on     = ($urandom_range(99) < 40) ? ~tracker.relay_cmd : tracker.relay_cmd;
		it.safe_ok     = ($urandom_range(99) < 90);
		it.feedback_on = ($urandom_range(99) < 85) ? tracker.relay_cmd : ~tracker.relay_cmd;
		return it;
	endfunction

	// Call at a falling edge; returns at the next falling edge after acceptance.
	task automatic send_item(item_t it);
		while (!(sent >= 400 && sent < 500) && $urandom_range(99) < 34) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.op          <= it.op;
		item_ch.now_ms      <= it.now_ms;
		item_ch.want_on     <= it.want_on;
		item_ch.safe_ok     <= it.safe_ok;
		item_ch.feedback_on <= it.feedback_on;
		do
			@(posedge clk);
		while (!item_ch.ready);
		tracker.note_tick(it);
		sent++;
		@(negedge clk);
	endtask

	task automatic program_regs(logic [SETTLE_W-1:0] s, logic [TS_W-1:0] b,
		logic [CHAT_W-1:0] c, logic [TS_W-1:0] w, logic [TS_W-1:0] l);
		logic [IDX_W-1:0]  idxs[5];
		logic [DATA_W-1:0] vals[5];
		idxs = '{REG_SETTLE_MS, REG_BREAK_MS, REG_CHATTER_LIMIT, REG_WINDOW_MS, REG_LOCK_MS};
		vals = '{DATA_W'(s), DATA_W'(b), DATA_W'(c), DATA_W'(w), DATA_W'(l)};
		for (int i = 0; i < 5; i++) begin
			wr_en    <= 1'b1;
			wr_index <= idxs[i];
			wr_data  <= vals[i];
			tracker.set_reg(idxs[i], vals[i]);
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic send_random(int count, bit allow_huge);
		for (int i = 0; i < count; i++)
			send_item(gen_tick(allow_huge));
	endtask

	initial begin
		item_ch.valid       = 1'b0;
		item_ch.op          = OP_TICK;
		item_ch.now_ms      = '0;
		item_ch.want_on     = 1'b0;
		item_ch.safe_ok     = 1'b0;
		item_ch.feedback_on = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: first tick, clear, unsafe, chatter trip, timestamp wrap
		send_item(tick_item(OP_TICK, 32'd0, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd100, 1'b1, 1'b1, 1'b1));
		send_item(tick_item(OP_CLEAR, 32'd150, 1'b0, 1'b0, 1'b1));
		send_item(tick_item(OP_TICK, 32'd700, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd800, 1'b1, 1'b0, 1'b1));
		send_item(tick_item(OP_TICK, 32'd900, 1'b0, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd1000, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd1100, 1'b0, 1'b1, 1'b1));
		send_item(tick_item(OP_TICK, 32'd1200, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd1300, 1'b0, 1'b1, 1'b1));
		send_item(tick_item(OP_TICK, 32'd1400, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd2000, 1'b1, 1'b1, 1'b1));
		send_item(tick_item(OP_CLEAR, 32'd3000, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'd400000, 1'b1, 1'b1, 1'b1));
		send_item(tick_item(OP_TICK, 32'd400100, 1'b0, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
		send_item(tick_item(OP_TICK, 32'h0000_0004, 1'b1, 1'b0, 1'b1));
		send_item(tick_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
		wait_drained();

		program_regs('0, '1, 4'd15, '0, '0);
		send_random(100, 1'b1);
		wait_drained();

		program_regs('1, '1, 4'd0, '1, '1);
		send_random(60, 1'b0);
		wait_drained();

		program_regs(SETTLE_W'($urandom_range(1000)), TS_W'($urandom_range(200000, 60000)),
			CHAT_W'($urandom_range(6, 2)), TS_W'($urandom_range(20000, 2000)),
			TS_W'($urandom_range(20000, 1000)));
		send_random(450, 1'b0);
		wait_drained();

		// latch the wire fault, then saturate the run time
		program_regs('0, '0, 4'd15, 32'd1000, 32'd500);
		send_item(tick_item(OP_TICK, cur_now + 32'd10, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, cur_now + 32'd600, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, cur_now + 32'd600, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, cur_now + 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1));
		send_item(tick_item(OP_TICK, cur_now + 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0));
		send_item(tick_item(OP_TICK, cur_now + 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1));
		send_random(50, 1'b1);
		wait_drained();

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("** pump_relay_supervisor_unit: PASSED **");
		end else begin
			$display("** pump_relay_supervisor_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		int hold_left;
		int cyc;
		bit hold_done;
		result_ch.ready = 1'b0;
		hold_left = 0;
		cyc = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!hold_done && sent >= 420) begin
				hold_left = 80;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (cyc >= 1500 && cyc < 2100) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 34);
			end
		end
	end

	always @(posedge clk) begin : sample_status
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.pump_on      = result_ch.pump_on;
			got.fault_lamp   = result_ch.fault_lamp;
			got.wire_fault   = result_ch.wire_fault;
			got.locked_out   = result_ch.locked_out;
			got.chatter_trip = result_ch.chatter_trip;
			got.run_total_ms = result_ch.run_total_ms;
			got.start_count  = result_ch.start_count;
			tracker.check_status(got);
		end
	end

	initial begin
		#5_000_000;
		$display("** pump_relay_supervisor_unit: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
sv/prs_pkg.sv
sv/prs_item_if.sv
sv/prs_result_if.sv
sv/prs_core.sv
sv/pump_relay_supervisor_unit.sv
sv/prs_checker.sv
bench/pump_relay_supervisor_unit_tb.sv
